// ===== rtl/bsc_pkg.sv =====
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric sensor compensation block.
// ---------------------------------------------------------------------------
package bsc_pkg;

  // field widths
  localparam int RawW   = 24;
  localparam int FracW  = 20;
  localparam int QuoW   = RawW + FracW;
  localparam int OutW   = 32;
  localparam int CfgW   = 48;
  localparam int ScaleW = 24;
  localparam int CfgIdxW = 3;

  // quotient bits resolved per divider stage
  localparam int DivBits = 4;
  // multiplier digit width (one digit per stage)
  localparam int MulDigitW = 11;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(524288);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCalLow    = 3'd0,
    CfgCalMid    = 3'd1,
    CfgCalHigh   = 3'd2,
    CfgTempScale = 3'd3,
    CfgPresScale = 3'd4
  } bsc_cfg_idx_e;

  // input word
  typedef struct packed {
    logic signed [RawW-1:0] raw_pressure;
    logic signed [RawW-1:0] raw_temperature;
  } bsc_in_t;

  // result word
  typedef struct packed {
    logic signed [OutW-1:0] pressure_comp;
    logic signed [OutW-1:0] temperature_comp;
  } bsc_out_t;

endpackage

// ===== rtl/bsc_div.sv =====
// ---------------------------------------------------------------------------
// bsc_div
// Pipelined signed restoring divider: raw * 2^20 / divisor, toward zero.
// ---------------------------------------------------------------------------
module bsc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [bsc_pkg::RawW-1:0]     raw_i,
  input  logic        [bsc_pkg::ScaleW-1:0]   div_i,
  output logic                                valid_o,
  output logic signed [bsc_pkg::QuoW-1:0]     quo_o
);

  localparam int QW  = bsc_pkg::QuoW;
  localparam int RW  = bsc_pkg::ScaleW;
  localparam int BPS = bsc_pkg::DivBits;
  localparam int NS  = QW / BPS;

  logic          v_q   [NS];
  logic          neg_q [NS];
  logic [QW-1:0] num_q [NS];
  logic [RW-1:0] rem_q [NS];
  logic [QW-1:0] quo_q [NS];

  logic                 out_v_q;
  logic signed [QW-1:0] out_q;

  logic [RW-1:0] mag;
  assign mag = raw_i[bsc_pkg::RawW-1] ? RW'(-raw_i) : RW'(raw_i);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          v_in;
    logic          neg_in;
    logic [QW-1:0] num_in;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] num_n;
    logic [RW-1:0] rem_n;
    logic [QW-1:0] quo_n;
    logic [RW:0]   r;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign neg_in = raw_i[bsc_pkg::RawW-1];
      assign num_in = {mag, {bsc_pkg::FracW{1'b0}}};
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign neg_in = neg_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // DivBits compare-subtract steps
    always_comb begin
      num_n = num_in;
      rem_n = rem_in;
      quo_n = quo_in;
      r     = '0;
      for (int i = 0; i < BPS; i++) begin
        r     = {rem_n, num_n[QW-1]};
        num_n = {num_n[QW-2:0], 1'b0};
        if (r >= {1'b0, div_i}) begin
          rem_n = RW'(r - {1'b0, div_i});
          quo_n = {quo_n[QW-2:0], 1'b1};
        end else begin
          rem_n = r[RW-1:0];
          quo_n = {quo_n[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[k] <= neg_in;
      num_q[k] <= num_n;
      rem_q[k] <= rem_n;
      quo_q[k] <= quo_n;
    end
  end

  // restore sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= neg_q[NS-1] ? -$signed(quo_q[NS-1]) : $signed(quo_q[NS-1]);
  end

  assign valid_o = out_v_q;
  assign quo_o   = out_q;

endmodule

// ===== rtl/bsc_mul.sv =====
// ---------------------------------------------------------------------------
// bsc_mul
// Pipelined multiply-add y = c + a * b, one digit of b per stage.
// ---------------------------------------------------------------------------
module bsc_mul #(
  parameter int WA = 16,
  parameter int WB = 44,
  parameter int WO = 61,
  parameter int WX = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  input  logic signed [WO-1:0] c_i,
  input  logic        [WX-1:0] x_i,
  output logic                 valid_o,
  output logic signed [WB-1:0] b_o,
  output logic signed [WO-1:0] y_o,
  output logic        [WX-1:0] x_o
);

  localparam int DW = bsc_pkg::MulDigitW;
  localparam int ND = (WB + DW - 1) / DW;
  localparam int WT = WB - (ND - 1) * DW;

  logic                 v_q   [ND];
  logic signed [WA-1:0] a_q   [ND];
  logic signed [WB-1:0] b_q   [ND];
  logic signed [WO-1:0] acc_q [ND];
  logic        [WX-1:0] x_q   [ND];

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic                    v_in;
    logic signed [WA-1:0]    a_in;
    logic signed [WB-1:0]    b_in;
    logic signed [WO-1:0]    acc_in;
    logic        [WX-1:0]    x_in;
    logic signed [DW:0]      dig;
    logic signed [WA+DW:0]   pp;
    logic signed [WO-1:0]    term;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign a_in   = a_i;
      assign b_in   = b_i;
      assign acc_in = c_i;
      assign x_in   = x_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
      assign x_in   = x_q[k-1];
    end

    // top digit carries the sign, the others are unsigned
    if (k == ND - 1) begin : g_top
      assign dig = (DW+1)'($signed(b_in[WB-1 -: WT]));
    end else begin : g_low
      assign dig = $signed({1'b0, b_in[k*DW +: DW]});
    end

    assign pp   = a_in * dig;
    assign term = WO'(pp) <<< (k * DW);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[k]   <= a_in;
      b_q[k]   <= b_in;
      acc_q[k] <= acc_in + term;
      x_q[k]   <= x_in;
    end
  end

  assign valid_o = v_q[ND-1];
  assign b_o     = b_q[ND-1];
  assign y_o     = acc_q[ND-1];
  assign x_o     = x_q[ND-1];

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Throughput: one word per cycle; busy is never raised and results cannot stall.
// Depth: divider, scale register, three 4-stage multiply-adds in series,
// sum register and result register.
// Reset clears all valid bits and sets calibration to zero, both scales to 524288.
// ---------------------------------------------------------------------------
// barometric_sensor_compensation
// Scales raw readings and evaluates the pressure and temperature polynomials.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bsc_pkg::bsc_in_t                  item_i,
  output logic                              done_o,
  output bsc_pkg::bsc_out_t                 result_o,
  input  logic                              cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bsc_pkg::CfgW-1:0]          cfg_wdata_i
);

  localparam int QW = bsc_pkg::QuoW;
  localparam int SW = bsc_pkg::ScaleW;
  localparam int CW = bsc_pkg::CfgW;
  localparam int W1 = 61;
  localparam int W2 = 106;
  localparam int W3 = 151;
  localparam int WS = 152;
  localparam int OW = bsc_pkg::OutW;

  // configuration registers
  logic [CW-1:0] cal_low_q, cal_mid_q, cal_high_q;
  logic [SW-1:0] tscale_q, pscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
      tscale_q   <= bsc_pkg::ScaleReset;
      pscale_q   <= bsc_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsc_pkg::CfgCalLow:    cal_low_q  <= cfg_wdata_i;
        bsc_pkg::CfgCalMid:    cal_mid_q  <= cfg_wdata_i;
        bsc_pkg::CfgCalHigh:   cal_high_q <= cfg_wdata_i;
        bsc_pkg::CfgTempScale: tscale_q   <= cfg_wdata_i[SW-1:0];
        bsc_pkg::CfgPresScale: pscale_q   <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // coefficient unpacking
  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0  = $signed(cal_low_q[47:36]);
  assign c1  = $signed(cal_low_q[35:24]);
  assign c00 = $signed(cal_low_q[23:4]);
  assign c10 = $signed({cal_low_q[3:0], cal_mid_q[47:32]});
  assign c01 = $signed(cal_mid_q[31:16]);
  assign c11 = $signed(cal_mid_q[15:0]);
  assign c20 = $signed(cal_high_q[47:32]);
  assign c21 = $signed(cal_high_q[31:16]);
  assign c30 = $signed(cal_high_q[15:0]);

  // a zero scale acts as one
  logic [SW-1:0] pdiv, tdiv;
  assign pdiv = (pscale_q == '0) ? SW'(1) : pscale_q;
  assign tdiv = (tscale_q == '0) ? SW'(1) : tscale_q;

  assign busy = 1'b0;

  // oversampling scale dividers
  logic                 pdiv_v;
  logic signed [QW-1:0] p_div, t_div;

  bsc_div u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .raw_i   (item_i.raw_pressure),
    .div_i   (pdiv),
    .valid_o (pdiv_v),
    .quo_o   (p_div)
  );

  bsc_div u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .raw_i   (item_i.raw_temperature),
    .div_i   (tdiv),
    .valid_o (),
    .quo_o   (t_div)
  );

  // temperature polynomial, truncated and saturated
  logic signed [55:0] c1t;
  logic signed [57:0] tq, tadj;
  logic signed [45:0] tsh;
  logic signed [OW-1:0] tres;

  assign c1t  = c1 * t_div;
  assign tq   = (58'(c0) <<< 19) + 58'(c1t);
  assign tadj = tq[57] ? tq + 58'sd4095 : tq;
  assign tsh  = 46'(tadj >>> 12);

  always_comb begin
    if (tsh > 46'sd2147483647) begin
      tres = 32'sh7FFFFFFF;
    end else if (tsh < -46'sd2147483648) begin
      tres = 32'sh80000000;
    end else begin
      tres = OW'(tsh);
    end
  end

  logic                 sc_v_q;
  logic signed [QW-1:0] p_q, t_q;
  logic signed [OW-1:0] tres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else begin
      sc_v_q <= pdiv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_div;
    t_q    <= t_div;
    tres_q <= tres;
  end

  // pressure terms in P only: ((c30*P + c20) * P + c10) * P + c00
  logic signed [QW-1:0] m1_b, m2_b;
  logic signed [W1-1:0] m1_y;
  logic signed [W2-1:0] m2_y;
  logic signed [W3-1:0] m3_y;

  bsc_mul #(.WA(16), .WB(QW), .WO(W1), .WX(1)) u_m1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sc_v_q),
    .a_i (c30), .b_i (p_q), .c_i (W1'(c20) <<< 20), .x_i (1'b0),
    .valid_o (), .b_o (m1_b), .y_o (m1_y), .x_o ()
  );

  bsc_mul #(.WA(W1), .WB(QW), .WO(W2), .WX(1)) u_m2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (1'b0),
    .a_i (m1_y), .b_i (m1_b), .c_i (W2'(c10) <<< 40), .x_i (1'b0),
    .valid_o (), .b_o (m2_b), .y_o (m2_y), .x_o ()
  );

  bsc_mul #(.WA(W2), .WB(QW), .WO(W3), .WX(1)) u_m3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (1'b0),
    .a_i (m2_y), .b_i (m2_b), .c_i (W3'(c00) <<< 60), .x_i (1'b0),
    .valid_o (), .b_o (), .y_o (m3_y), .x_o ()
  );

  // cross terms: ((c21*P + c11) * P + c01) * T
  localparam int XW = QW + OW;

  logic                 n1_v, n2_v, n3_v;
  logic signed [QW-1:0] n1_b;
  logic signed [W1-1:0] n1_y;
  logic signed [W2-1:0] n2_y;
  logic signed [W3-1:0] n3_y;
  logic [XW-1:0]        n1_x, n2_x;
  logic [OW-1:0]        n3_x;

  bsc_mul #(.WA(16), .WB(QW), .WO(W1), .WX(XW)) u_n1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sc_v_q),
    .a_i (c21), .b_i (p_q), .c_i (W1'(c11) <<< 20), .x_i ({t_q, tres_q}),
    .valid_o (n1_v), .b_o (n1_b), .y_o (n1_y), .x_o (n1_x)
  );

  bsc_mul #(.WA(W1), .WB(QW), .WO(W2), .WX(XW)) u_n2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (n1_v),
    .a_i (n1_y), .b_i (n1_b), .c_i (W2'(c01) <<< 40), .x_i (n1_x),
    .valid_o (n2_v), .b_o (), .y_o (n2_y), .x_o (n2_x)
  );

  bsc_mul #(.WA(W2), .WB(QW), .WO(W3), .WX(OW)) u_n3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (n2_v),
    .a_i (n2_y), .b_i ($signed(n2_x[XW-1:OW])), .c_i ('0), .x_i (n2_x[OW-1:0]),
    .valid_o (n3_v), .b_o (), .y_o (n3_y), .x_o (n3_x)
  );

  // sum of both chains
  logic                 sum_v_q;
  logic signed [WS-1:0] sum_q;
  logic signed [OW-1:0] tout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else begin
      sum_v_q <= n3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= WS'(m3_y) + WS'(n3_y);
    tout_q <= $signed(n3_x);
  end

  // cut to 8 fraction bits toward zero and saturate
  localparam logic signed [WS-1:0] PRnd = (WS'(1) <<< 52) - WS'(1);

  logic signed [WS-1:0]  padj;
  logic signed [WS-53:0] psh;
  logic signed [OW-1:0]  pres;

  assign padj = sum_q[WS-1] ? sum_q + PRnd : sum_q;
  assign psh  = (WS-52)'(padj >>> 52);

  always_comb begin
    if (psh > 100'sd2147483647) begin
      pres = 32'sh7FFFFFFF;
    end else if (psh < -100'sd2147483648) begin
      pres = 32'sh80000000;
    end else begin
      pres = OW'(psh);
    end
  end

  // result register
  logic              done_q;
  bsc_pkg::bsc_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.pressure_comp    <= pres;
    res_q.temperature_comp <= tout_q;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
